// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, ck, rs, a, c)
`define ASSERT_NEXT(lbl, ck, rs, a, c)
`endif
`endif

// ----- rtl/core/ntl_pkg.sv -----
// Shared types, constants and helpers of the neighbor table.
package ntl_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    REQ_SEEN   = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_SNAP   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [31:0] now;
    logic        hashed;
    logic [63:0] key;
    logic [31:0] pay;
    logic [31:0] max_age;
    logic [6:0]  max_n;
  } req_t;

  function automatic logic older(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ----- rtl/core/ntl_front.sv -----
// Front end: take request beats, decode and mask them, push to the queue.
module ntl_front
  import ntl_pkg::*;
#(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic        key_is_hash,
  input  logic [63:0] key_value,
  input  logic [31:0] payload,
  input  logic [31:0] max_age_ms,
  input  logic [6:0]  max_entries,
  output logic        q_push,
  input  logic        q_full,
  output req_t        q_req
);

  req_kind_t kind;

  always_comb begin
    unique case (req_type)
      2'd0:    kind = REQ_SEEN;
      2'd1:    kind = REQ_LOOKUP;
      2'd2:    kind = REQ_COUNT;
      default: kind = REQ_SNAP;
    endcase
  end

  always_comb begin
    q_req.kind    = kind;
    q_req.now     = now_ms;
    q_req.hashed  = key_is_hash;
    q_req.max_age = max_age_ms;
    q_req.max_n   = max_entries;
    for (int b = 0; b < 64; b++) begin
      q_req.key[b] = (b < KEY_BITS) ? key_value[b] : 1'b0;
    end
    for (int b = 0; b < 32; b++) begin
      q_req.pay[b] = (b < PAYLOAD_BITS) ? payload[b] : 1'b0;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- rtl/core/ntl_queue.sv -----
// Two-entry request queue between front and back.
module ntl_queue
  import ntl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic full,
  output logic pop_vld,
  input  logic pop,
  output req_t pop_data
);

  req_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign pop_vld  = (cnt != 2'd0);
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/core/ntl_back.sv -----
// Back end: table storage, scans, insertion sort and result register.
`include "assert_macros.svh"
module ntl_back
  import ntl_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_vld,
  output logic        q_pop,
  input  req_t        q_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        is_hash,
  output logic [63:0] entry_key,
  output logic [31:0] entry_payload,
  output logic [31:0] entry_time,
  output logic [31:0] entry_count,
  output logic [6:0]  live_total,
  output logic        last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);

  typedef struct packed {
    logic                h;
    logic [KEY_BITS-1:0] key;
    logic [PW-1:0]       pay;
    logic [31:0]         tm;
    logic [31:0]         cnt;
  } rec_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [31:0]   tm;
  } sent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FIN, S_DONE, S_SEEN_WR, S_OUT,
    S_SN_SCAN, S_SN_TM, S_SN_INS, S_SN_CMP,
    S_EM_RD, S_EM_WAIT, S_EM_TBL
  } st_t;

  st_t           st;
  req_t          cur;
  logic [ENTRIES-1:0] vld;
  logic [IW-1:0] s;
  logic          p_vld;
  logic [IW-1:0] p_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  rec_t          hit_rec;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_idx;
  logic [31:0]   old_tm;
  logic [IW-1:0] wsel;
  logic [CW-1:0] live;
  logic [CW-1:0] k;
  logic [CW-1:0] j;
  logic [CW-1:0] jm1;
  logic [CW-1:0] i;
  sent_t         t;

  rec_t          tbl [ENTRIES];
  rec_t          tbl_q;
  logic          tbl_re;
  logic [IW-1:0] tbl_ra;
  logic          tbl_we;
  rec_t          wrec;

  sent_t         srt [ENTRIES];
  sent_t         srt_q;
  logic          srt_re;
  logic [IW-1:0] srt_ra;
  logic          srt_we;
  logic [IW-1:0] srt_wa;
  sent_t         srt_wd;

  logic          ofree;
  logic          emit_now;
  logic [31:0]   age;
  logic          take;

  assign ofree    = !out_valid || !out_stall;
  assign emit_now = ofree && (st == S_OUT || (st == S_EM_RD && k == '0) || st == S_EM_TBL);
  assign q_pop    = (st == S_IDLE) && q_vld;
  assign jm1      = j - CW'(1);
  assign age      = cur.now - tbl_q.tm;
  assign take     = vld[s] && (7'(k) < cur.max_n);

  always_comb begin
    wrec.h   = cur.hashed;
    wrec.key = cur.key[KEY_BITS-1:0];
    wrec.pay = cur.pay[PW-1:0];
    wrec.tm  = cur.now;
    wrec.cnt = (hit ? hit_rec.cnt : 32'd0) + 32'd1;
  end

  always_comb begin
    tbl_re = 1'b0;
    tbl_ra = s;
    tbl_we = (st == S_SEEN_WR);
    srt_re = 1'b0;
    srt_ra = jm1[IW-1:0];
    srt_we = 1'b0;
    srt_wa = j[IW-1:0];
    srt_wd = t;
    unique case (st)
      S_SCAN:    tbl_re = 1'b1;
      S_SN_SCAN: tbl_re = take;
      S_EM_WAIT: begin
        tbl_re = 1'b1;
        tbl_ra = srt_q.idx;
      end
      S_SN_INS: begin
        srt_re = (j != '0);
        srt_we = (j == '0);
      end
      S_SN_CMP: begin
        srt_we = 1'b1;
        if (older(srt_q.tm, t.tm)) srt_wd = srt_q;
      end
      S_EM_RD: begin
        srt_re = 1'b1;
        srt_ra = i[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[wsel] <= wrec;
    if (tbl_re) tbl_q <= tbl[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (srt_we) srt[srt_wa] <= srt_wd;
    if (srt_re) srt_q <= srt[srt_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      vld       <= '0;
      p_vld     <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (p_vld) begin
        if (vld[p_idx] && !hit && tbl_q.h == cur.hashed &&
            tbl_q.key == cur.key[KEY_BITS-1:0]) begin
          hit     <= 1'b1;
          hit_idx <= p_idx;
          hit_rec <= tbl_q;
        end
        if (!vld[p_idx] && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= p_idx;
        end
        if (p_idx == '0 || older(tbl_q.tm, old_tm)) begin
          old_idx <= p_idx;
          old_tm  <= tbl_q.tm;
        end
        if (vld[p_idx] && age <= cur.max_age) live <= live + CW'(1);
      end

      unique case (st)
        S_IDLE: begin
          if (q_vld) begin
            cur     <= q_data;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            live    <= '0;
            k       <= '0;
            s       <= '0;
            p_vld   <= 1'b0;
            st      <= (q_data.kind == REQ_SNAP) ? S_SN_SCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          p_vld <= 1'b1;
          p_idx <= s;
          if (s == LAST_SLOT) st <= S_FIN;
          else s <= s + IW'(1);
        end
        S_FIN: begin
          p_vld <= 1'b0;
          st    <= S_DONE;
        end
        S_DONE: begin
          wsel <= hit ? hit_idx : (free_ok ? free_idx : old_idx);
          st   <= (cur.kind == REQ_SEEN) ? S_SEEN_WR : S_OUT;
        end
        S_SEEN_WR: begin
          vld[wsel] <= 1'b1;
          hit_rec   <= wrec;
          st        <= S_OUT;
        end
        S_OUT: begin
          if (ofree) begin
            last       <= 1'b1;
            found      <= hit && (cur.kind != REQ_COUNT);
            live_total <= (cur.kind == REQ_COUNT) ? 7'(live) : '0;
            if (cur.kind != REQ_COUNT && (hit || cur.kind == REQ_SEEN)) begin
              is_hash       <= hit_rec.h;
              entry_key     <= 64'(hit_rec.key);
              entry_payload <= 32'(hit_rec.pay);
              entry_time    <= hit_rec.tm;
              entry_count   <= hit_rec.cnt;
            end else begin
              is_hash       <= 1'b0;
              entry_key     <= '0;
              entry_payload <= '0;
              entry_time    <= '0;
              entry_count   <= '0;
            end
            st <= S_IDLE;
          end
        end
        S_SN_SCAN: begin
          if (take) begin
            st <= S_SN_TM;
          end else if (s == LAST_SLOT) begin
            i  <= '0;
            st <= S_EM_RD;
          end else begin
            s <= s + IW'(1);
          end
        end
        S_SN_TM: begin
          t  <= '{idx: s, tm: tbl_q.tm};
          j  <= k;
          st <= S_SN_INS;
        end
        S_SN_INS: begin
          if (j == '0) begin
            k <= k + CW'(1);
            if (s == LAST_SLOT) begin
              i  <= '0;
              st <= S_EM_RD;
            end else begin
              s  <= s + IW'(1);
              st <= S_SN_SCAN;
            end
          end else begin
            st <= S_SN_CMP;
          end
        end
        S_SN_CMP: begin
          if (older(srt_q.tm, t.tm)) begin
            j  <= jm1;
            st <= S_SN_INS;
          end else begin
            k <= k + CW'(1);
            if (s == LAST_SLOT) begin
              i  <= '0;
              st <= S_EM_RD;
            end else begin
              s  <= s + IW'(1);
              st <= S_SN_SCAN;
            end
          end
        end
        S_EM_RD: begin
          if (k == '0) begin
            if (ofree) begin
              found         <= 1'b0;
              is_hash       <= 1'b0;
              entry_key     <= '0;
              entry_payload <= '0;
              entry_time    <= '0;
              entry_count   <= '0;
              live_total    <= '0;
              last          <= 1'b1;
              st            <= S_IDLE;
            end
          end else begin
            st <= S_EM_WAIT;
          end
        end
        S_EM_WAIT: st <= S_EM_TBL;
        S_EM_TBL: begin
          if (ofree) begin
            found         <= 1'b1;
            is_hash       <= tbl_q.h;
            entry_key     <= 64'(tbl_q.key);
            entry_payload <= 32'(tbl_q.pay);
            entry_time    <= tbl_q.tm;
            entry_count   <= tbl_q.cnt;
            live_total    <= '0;
            last          <= (CW'(i + CW'(1)) == k);
            if (CW'(i + CW'(1)) == k) begin
              st <= S_IDLE;
            end else begin
              i  <= i + CW'(1);
              st <= S_EM_RD;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_k_range, clk, rst, 1'b1, k <= CW'(ENTRIES))
  `ASSERT_IMPL(a_j_range, clk, rst, st == S_SN_CMP, (j != '0) && (j <= k))
  `ASSERT_IMPL(a_free_slot, clk, rst, st == S_SEEN_WR && !hit && free_ok, !vld[wsel])
  `ASSERT_NEXT(a_slot_live, clk, rst, st == S_SEEN_WR, vld != '0)

endmodule

// ----- rtl/core/neighbor_table_lru_unit.sv -----
// Neighbor table with LRU replacement: top level.
// One request is handled at a time. The front decodes each beat into a
// two-entry queue, so up to two requests are taken while the back is busy.
// Seen, lookup and count requests walk every slot through the single read
// port of the entry memory. A snapshot walks the slots once, inserts each
// gathered slot into a sorted list in a second memory, with an insert and
// a compare step per position moved, then emits each item by reading the
// sorted list, reading the entry memory and then sending that entry out.
// Results leave through an output register, so a stalled result holds the
// back only when the next result is ready.
module neighbor_table_lru_unit
  import ntl_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic        key_is_hash,
  input  logic [63:0] key_value,
  input  logic [31:0] payload,
  input  logic [31:0] max_age_ms,
  input  logic [6:0]  max_entries,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        is_hash,
  output logic [63:0] entry_key,
  output logic [31:0] entry_payload,
  output logic [31:0] entry_time,
  output logic [31:0] entry_count,
  output logic [6:0]  live_total,
  output logic        last
);

  logic q_push;
  logic q_full;
  req_t q_req;
  logic q_vld;
  logic q_pop;
  req_t q_head;

  ntl_front #(
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .now_ms      (now_ms),
    .key_is_hash (key_is_hash),
    .key_value   (key_value),
    .payload     (payload),
    .max_age_ms  (max_age_ms),
    .max_entries (max_entries),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_req       (q_req)
  );

  ntl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_req),
    .full      (q_full),
    .pop_vld   (q_vld),
    .pop       (q_pop),
    .pop_data  (q_head)
  );

  ntl_back #(
    .ENTRIES      (ENTRIES),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_vld         (q_vld),
    .q_pop         (q_pop),
    .q_data        (q_head),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .is_hash       (is_hash),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .entry_time    (entry_time),
    .entry_count   (entry_count),
    .live_total    (live_total),
    .last          (last)
  );

endmodule
